// ----- src/pcsb_pkg.sv -----
// ----------------------------------------------------------------------------
// pcsb_pkg: shared types and constants of the scan binner
// Word types, status/register/state enums, opcodes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pcsb_pkg;

	localparam int CORDIC_STEPS = 17;
	localparam logic signed [18:0] PI_Q16      = 19'sd205887;
	localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;

	typedef enum logic [2:0] {
		ST_STORED     = 3'd0,
		ST_NOT_CLOSER = 3'd1,
		ST_HEIGHT     = 3'd2,
		ST_TOO_NEAR   = 3'd3,
		ST_TOO_FAR    = 3'd4,
		ST_ANGLE      = 3'd5,
		ST_BEYOND     = 3'd6,
		ST_READ       = 3'd7
	} status_t;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		REG_MIN_HEIGHT = 3'd0,
		REG_MAX_HEIGHT = 3'd1,
		REG_RANGE_MIN  = 3'd2,
		REG_RANGE_MAX  = 3'd3,
		REG_ANGLE_MIN  = 3'd4,
		REG_ANGLE_MAX  = 3'd5,
		REG_ANGLE_INC  = 3'd6,
		REG_EMPTY_FILL = 3'd7
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_SQRT, S_CORDIC, S_DIV, S_LOOKUP, S_UPDATE, S_OUT
	} state_t;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [9:0]         bin_select;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  bin_index;
		logic [31:0] range_value;
	} out_word_t;

	// Arctangent of 2^-i in Q16 radians.
	function automatic logic [15:0] atan_entry(input logic [4:0] i);
		logic [15:0] v;
		case (i)
			5'd0:  v = 16'd51472;
			5'd1:  v = 16'd30386;
			5'd2:  v = 16'd16055;
			5'd3:  v = 16'd8150;
			5'd4:  v = 16'd4091;
			5'd5:  v = 16'd2047;
			5'd6:  v = 16'd1024;
			5'd7:  v = 16'd512;
			5'd8:  v = 16'd256;
			5'd9:  v = 16'd128;
			5'd10: v = 16'd64;
			5'd11: v = 16'd32;
			5'd12: v = 16'd16;
			5'd13: v = 16'd8;
			5'd14: v = 16'd4;
			5'd15: v = 16'd2;
			5'd16: v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/pcsb_ram.sv -----
// ----------------------------------------------------------------------------
// pcsb_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module pcsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- src/point_cloud_to_scan_binner_top.sv -----
// ----------------------------------------------------------------------------
// point_cloud_to_scan_binner_top: point cloud to planar scan binner
// Bins 3D points by angle and keeps the nearest planar range per bin.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready) are either an add-point or a read-and-clear
// request. Every input word yields exactly one output word (out_valid/
// out_ready) carrying a status code, a bin index and a range.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the block is idle; the block does not enforce it.
// One word is processed at a time. A stored or not-closer add passes through
// the bit-serial square root, the CORDIC (setup plus 17 iterations), a
// 22-step restoring divider for the bin number, then lookup, update and output.
// A height reject goes straight to output, a range reject leaves after the
// square root, an angle reject after the CORDIC, a bin-beyond reject after the
// lookup, and a read runs through lookup, update and output.
// The result sits in an output register; a new input is taken in the cycle
// after the previous result has been delivered.
// After reset a clearing pass walks all MAX_BINS entries of the filled-flag
// memory, one entry per cycle; no input is accepted during it.
// A stalled receiver simply holds the output register and the input side.
// ----------------------------------------------------------------------------
module point_cloud_to_scan_binner_top #(
	parameter int MAX_BINS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pcsb_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pcsb_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import pcsb_pkg::*;

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CW = AW + 1;
	localparam int DIV_STEPS = 22;

	// Configuration registers.
	logic signed [31:0] min_height_q, max_height_q;
	logic [31:0]        range_min_q, range_max_q, empty_fill_q;
	logic signed [18:0] angle_min_q, angle_max_q;
	logic [18:0]        angle_inc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_height_q <= 32'sh8000_0000;
			max_height_q <= 32'sh7FFF_FFFF;
			range_min_q  <= '0;
			range_max_q  <= '1;
			angle_min_q  <= -PI_Q16;
			angle_max_q  <= PI_Q16;
			angle_inc_q  <= 19'd1144;
			empty_fill_q <= '1;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MIN_HEIGHT: min_height_q <= cfg_data;
				REG_MAX_HEIGHT: max_height_q <= cfg_data;
				REG_RANGE_MIN:  range_min_q  <= cfg_data;
				REG_RANGE_MAX:  range_max_q  <= cfg_data;
				REG_ANGLE_MIN:  angle_min_q  <= cfg_data[18:0];
				REG_ANGLE_MAX:  angle_max_q  <= cfg_data[18:0];
				REG_ANGLE_INC:  angle_inc_q  <= cfg_data[18:0];
				REG_EMPTY_FILL: empty_fill_q <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	in_word_t in_q;
	logic [5:0] cnt_q;
	logic [AW-1:0] clr_q;

	// Square root datapath (bit-serial, two radicand bits per cycle).
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] range_q;

	// CORDIC datapath (operands scaled by 2^20 fit in 53 bits plus growth).
	logic signed [55:0] cx_q, cy_q;
	logic signed [19:0] acc_q;

	// Divider datapath.
	logic [21:0] dnum_q, dquo_q;
	logic [19:0] drem_q;

	logic [2:0]    status_q;
	logic [9:0]    bin_out_q;
	logic [AW-1:0] addr_q;
	logic          oob_read_q;
	out_word_t     out_q;
	logic          out_valid_q;

	// Bin count: ceil(span/inc) compared as bin*inc >= span, done by
	// checking that bin < count with the product test below.
	logic [18:0] inc_eff;
	assign inc_eff = (angle_inc_q == '0) ? 19'd1 : angle_inc_q;

	// Memories.
	logic          rng_we, flg_we, flg_wdata;
	logic [AW-1:0] mem_addr;
	logic [31:0]   rng_rdata;
	logic          flg_rdata;
	logic [31:0]   rng_wdata;

	pcsb_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_range_ram (
		.clk(clk), .we(rng_we), .addr(mem_addr), .wdata(rng_wdata), .rdata(rng_rdata)
	);
	pcsb_ram #(.WIDTH(1), .DEPTH(MAX_BINS)) u_flag_ram (
		.clk(clk), .we(flg_we), .addr(mem_addr), .wdata(flg_wdata), .rdata(flg_rdata)
	);

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	// Square root step.
	logic [33:0] sq_trial;
	logic [33:0] sq_rem_sh;
	assign sq_rem_sh = {rem_q[31:0], rad_q[63:62]};
	assign sq_trial  = sq_rem_sh - {root_q, 2'b01};

	// CORDIC step; iteration cnt performs step cnt-1.
	logic signed [55:0] cdx, cdy;
	assign cdx = cy_q >>> (cnt_q[4:0] - 5'd1);
	assign cdy = cx_q >>> (cnt_q[4:0] - 5'd1);

	// Divider step.
	logic [19:0] dv_sh;
	logic [20:0] dv_diff;
	assign dv_sh   = {drem_q[18:0], dnum_q[21]};
	assign dv_diff = {1'b0, dv_sh} - {2'b00, inc_eff};

	// The origin has angle zero by definition.
	logic pt_zero;
	assign pt_zero = (in_q.pos_x == '0) && (in_q.pos_y == '0);

	// Angle offset and span.
	logic signed [19:0] ang_sat, ang_off, span;
	always_comb begin
		if (pt_zero) ang_sat = '0;
		else if (acc_q > 20'(PI_Q16)) ang_sat = 20'(PI_Q16);
		else if (acc_q < -20'(PI_Q16)) ang_sat = -20'(PI_Q16);
		else ang_sat = acc_q;
	end
	assign ang_off = ang_sat - 20'(angle_min_q);
	assign span    = 20'(angle_max_q) - 20'(angle_min_q);

	// bin < ceil(span/inc) is equivalent to bin*inc < span; bin*inc <= ang_off
	// here, so test quotient against span with the quotient's product.
	logic [40:0] bin_prod;
	logic [21:0] bin_q_reg;
	logic        beyond;
	assign bin_prod = 41'(bin_q_reg) * 41'(inc_eff);
	assign beyond = (span <= 0) || (bin_prod >= 41'(span)) ||
		(bin_q_reg >= 22'(MAX_BINS));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (clr_q == AW'(MAX_BINS - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (in_fire) begin
					if (in_data.opcode == OP_READ) state_d = S_LOOKUP;
					else if (in_data.pos_z > max_height_q ||
						in_data.pos_z < min_height_q) state_d = S_OUT;
					else state_d = S_SQRT;
				end
			end
			S_SQRT:   if (cnt_q == 6'd31) state_d = S_CORDIC;
			S_CORDIC: begin
				if (range_q < range_min_q || range_q > range_max_q) state_d = S_OUT;
				else if (cnt_q == 6'(CORDIC_STEPS)) state_d = S_DIV;
			end
			S_DIV: begin
				if (cnt_q == 6'd0 && (ang_sat < 20'(angle_min_q) ||
					ang_sat > 20'(angle_max_q))) state_d = S_OUT;
				else if (cnt_q == 6'(DIV_STEPS + 1)) state_d = S_LOOKUP;
			end
			S_LOOKUP: state_d = (in_q.opcode == OP_ADD && beyond) ? S_OUT : S_UPDATE;
			S_UPDATE: state_d = S_OUT;
			S_OUT:    if (!out_valid_q) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory control.
	logic closer;
	assign closer = !flg_rdata || (range_q < rng_rdata);
	always_comb begin
		rng_we = 1'b0;
		flg_we = 1'b0;
		flg_wdata = 1'b0;
		rng_wdata = range_q;
		mem_addr = addr_q;
		case (state_q)
			S_CLEAR: begin
				flg_we = 1'b1;
				mem_addr = clr_q;
			end
			S_UPDATE: begin
				if (in_q.opcode == OP_READ) begin
					flg_we = !oob_read_q;
				end else if (closer) begin
					rng_we = 1'b1;
					flg_we = 1'b1;
					flg_wdata = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			else if (state_q == S_OUT && !out_valid_q) out_valid_q <= 1'b1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				in_q  <= in_data;
				cnt_q <= '0;
				rad_q <= 64'(64'(signed'(in_data.pos_x)) * 64'(signed'(in_data.pos_x))) +
					64'(64'(signed'(in_data.pos_y)) * 64'(signed'(in_data.pos_y)));
				rem_q  <= '0;
				root_q <= '0;
				oob_read_q <= ({22'd0, in_data.bin_select} >= 32'(MAX_BINS));
				addr_q <= AW'(in_data.bin_select);
				if (in_data.opcode == OP_ADD) begin
					status_q  <= ST_HEIGHT;
					bin_out_q <= '0;
					range_q   <= '0;
				end else begin
					status_q  <= ST_READ;
					bin_out_q <= in_data.bin_select;
				end
			end
			S_SQRT: begin
				rad_q <= {rad_q[61:0], 2'b00};
				if (!sq_trial[33]) begin
					rem_q  <= sq_trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= sq_rem_sh;
					root_q <= {root_q[30:0], 1'b0};
				end
				if (cnt_q == 6'd31) begin
					range_q <= (!sq_trial[33]) ? {root_q[30:0], 1'b1} : {root_q[30:0], 1'b0};
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			S_CORDIC: begin
				if (range_q < range_min_q) status_q <= ST_TOO_NEAR;
				else if (range_q > range_max_q) status_q <= ST_TOO_FAR;
				if (cnt_q == 6'd0) begin
					// Setup: scale and pre-rotate into the right half plane.
					if (in_q.pos_x < 0 && in_q.pos_y >= 0) begin
						cx_q  <= 56'(signed'(in_q.pos_y)) <<< 20;
						cy_q  <= -(56'(signed'(in_q.pos_x)) <<< 20);
						acc_q <= 20'(HALF_PI_Q16);
					end else if (in_q.pos_x < 0) begin
						cx_q  <= -(56'(signed'(in_q.pos_y)) <<< 20);
						cy_q  <= 56'(signed'(in_q.pos_x)) <<< 20;
						acc_q <= -20'(HALF_PI_Q16);
					end else begin
						cx_q  <= 56'(signed'(in_q.pos_x)) <<< 20;
						cy_q  <= 56'(signed'(in_q.pos_y)) <<< 20;
						acc_q <= '0;
					end
					cnt_q <= 6'd1;
				end else begin
					if (cy_q > 0) begin
						cx_q  <= cx_q + cdx;
						cy_q  <= cy_q - cdy;
						acc_q <= acc_q + 20'(atan_entry(5'(cnt_q - 6'd1)));
					end else begin
						cx_q  <= cx_q - cdx;
						cy_q  <= cy_q + cdy;
						acc_q <= acc_q - 20'(atan_entry(5'(cnt_q - 6'd1)));
					end
					if (cnt_q == 6'(CORDIC_STEPS)) cnt_q <= '0;
					else cnt_q <= cnt_q + 6'd1;
				end
				// CORDIC steps index by cnt-1; keep the shifts aligned.
			end
			S_DIV: begin
				if (cnt_q == 6'd0) begin
					status_q <= ST_ANGLE;
					dnum_q <= 22'(ang_off);
					drem_q <= '0;
					dquo_q <= '0;
				end else if (cnt_q <= 6'(DIV_STEPS)) begin
					dnum_q <= {dnum_q[20:0], 1'b0};
					if (!dv_diff[20]) begin
						drem_q <= dv_diff[19:0];
						dquo_q <= {dquo_q[20:0], 1'b1};
					end else begin
						drem_q <= dv_sh;
						dquo_q <= {dquo_q[20:0], 1'b0};
					end
				end else begin
					bin_q_reg <= dquo_q;
					addr_q    <= AW'(dquo_q);
				end
				cnt_q <= cnt_q + 6'd1;
			end
			S_LOOKUP: begin
				if (in_q.opcode == OP_ADD) begin
					bin_out_q <= (bin_q_reg > 22'd1023) ? 10'd1023 : bin_q_reg[9:0];
					status_q  <= beyond ? ST_BEYOND : ST_STORED;
				end
			end
			S_UPDATE: begin
				if (in_q.opcode == OP_READ) begin
					range_q <= (!oob_read_q && flg_rdata) ? rng_rdata : empty_fill_q;
				end else if (!closer) begin
					status_q <= ST_NOT_CLOSER;
				end
			end
			S_OUT: begin
				out_q.status      <= status_q;
				out_q.bin_index   <= bin_out_q;
				out_q.range_value <= range_q;
			end
			default: ;
		endcase
	end

	// Assertions.
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !out_valid) else $error("output present after accept");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready) else $error("accept during clear");
	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		rng_we |-> (state_q == S_UPDATE && in_q.opcode == OP_ADD))
		else $error("range write outside update");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("output dropped");
endmodule
